// File: hw/rtl/mjcc_pkg.sv
// ----------------------------------------------------------------------------
// mjcc_pkg
// Shared types and constants of the mecanum jog command controller: beat
// payloads, the configuration bundle, register indexes and command codes.
// ----------------------------------------------------------------------------
package mjcc_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [6:0]  SPEED_LIMIT         = 7'd100;
   localparam logic [6:0]  JOG_SPEED_RESET     = 7'd35;
   localparam logic [15:0] JOG_TICKS_RESET     = 16'd450;
   localparam logic [7:0]  OPEN_ANGLE_RESET    = 8'd60;
   localparam logic [7:0]  CLOSED_ANGLE_RESET  = 8'd10;
   localparam logic [7:0]  SERVO_RESET_ANGLE   = 8'd10;

   localparam logic [7:0] CMD_FORWARD   = 8'h66;
   localparam logic [7:0] CMD_BACK      = 8'h62;
   localparam logic [7:0] CMD_LEFT      = 8'h6c;
   localparam logic [7:0] CMD_RIGHT     = 8'h72;
   localparam logic [7:0] CMD_ROT_CCW   = 8'h71;
   localparam logic [7:0] CMD_ROT_CW    = 8'h65;
   localparam logic [7:0] CMD_STOP      = 8'h73;
   localparam logic [7:0] CMD_GRIP_TOG  = 8'h67;
   localparam logic [7:0] CMD_GRIP_OPEN = 8'h6f;
   localparam logic [7:0] CMD_GRIP_CLS  = 8'h63;

   localparam logic ACTION_COMMAND = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   typedef enum logic [1:0] {
      REG_JOG_SPEED    = 2'd0,
      REG_JOG_TICKS    = 2'd1,
      REG_OPEN_ANGLE   = 2'd2,
      REG_CLOSED_ANGLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic       action;
      logic [7:0] command;
   } req_type;

   typedef struct packed {
      logic signed [7:0] wheel_one;
      logic signed [7:0] wheel_two;
      logic signed [7:0] wheel_three;
      logic signed [7:0] wheel_four;
      logic              motors_written;
      logic [7:0]        servo_angle;
      logic              servo_written;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  jog_speed;
      logic [15:0] jog_ticks;
      logic [7:0]  open_angle;
      logic [7:0]  closed_angle;
   } cfg_type;

endpackage

// File: hw/rtl/mjcc_csr.sv
// ----------------------------------------------------------------------------
// mjcc_csr
// Configuration register file behind the APB-style port: jog speed, jog
// length in ticks and the two gripper servo angles.
// ----------------------------------------------------------------------------
module mjcc_csr import mjcc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_JOG_SPEED:    cfg_in.jog_speed    = csr_pwdata[6:0];
            REG_JOG_TICKS:    cfg_in.jog_ticks    = csr_pwdata[15:0];
            REG_OPEN_ANGLE:   cfg_in.open_angle   = csr_pwdata[7:0];
            REG_CLOSED_ANGLE: cfg_in.closed_angle = csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_JOG_SPEED:    csr_prdata = {25'd0, cfg_ff.jog_speed};
         REG_JOG_TICKS:    csr_prdata = {16'd0, cfg_ff.jog_ticks};
         REG_OPEN_ANGLE:   csr_prdata = {24'd0, cfg_ff.open_angle};
         REG_CLOSED_ANGLE: csr_prdata = {24'd0, cfg_ff.closed_angle};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jog_speed    <= JOG_SPEED_RESET;
         cfg_ff.jog_ticks    <= JOG_TICKS_RESET;
         cfg_ff.open_angle   <= OPEN_ANGLE_RESET;
         cfg_ff.closed_angle <= CLOSED_ANGLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/mjcc_core.sv
// ----------------------------------------------------------------------------
// mjcc_core
// Controller state and the single-pass update for one item: command decode,
// wheel mixing with clamping, jog countdown and gripper control.
// ----------------------------------------------------------------------------
module mjcc_core import mjcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [15:0]      ticks_ff;
   logic [15:0]      ticks_in;
   logic             active_ff;
   logic             active_in;
   logic             open_ff;
   logic             open_in;
   logic [3:0][7:0]  wheel_ff;
   logic [3:0][7:0]  wheel_in;
   logic [7:0]       servo_ff;
   logic [7:0]       servo_in;
   logic             motors_written;
   logic             servo_written;
   logic [6:0]       speed_mag;
   logic [7:0]       pos;
   logic [7:0]       neg;
   logic             jog_start;

   // Only one axis moves per jog, so the rotation scaling never meets a
   // nonzero x or y and each wheel is plus or minus the clamped speed.
   assign speed_mag = (cfg.jog_speed > SPEED_LIMIT) ? SPEED_LIMIT : cfg.jog_speed;
   assign pos       = {1'b0, speed_mag};
   assign neg       = 8'd0 - pos;

   always_comb begin
      ticks_in       = ticks_ff;
      active_in      = active_ff;
      open_in        = open_ff;
      wheel_in       = wheel_ff;
      servo_in       = servo_ff;
      motors_written = 1'b0;
      servo_written  = 1'b0;
      jog_start      = 1'b0;
      if (item.action == ACTION_TICK) begin
         if (active_ff) begin
            if (ticks_ff <= 16'd1) begin
               wheel_in       = '0;
               ticks_in       = '0;
               active_in      = 1'b0;
               motors_written = 1'b1;
            end else begin
               ticks_in = ticks_ff - 16'd1;
            end
         end
      end else begin
         unique case (item.command)
            CMD_FORWARD: begin
               wheel_in  = {pos, pos, pos, pos};
               jog_start = 1'b1;
            end
            CMD_BACK: begin
               wheel_in  = {neg, neg, neg, neg};
               jog_start = 1'b1;
            end
            CMD_LEFT: begin
               wheel_in  = {neg, pos, pos, neg};
               jog_start = 1'b1;
            end
            CMD_RIGHT: begin
               wheel_in  = {pos, neg, neg, pos};
               jog_start = 1'b1;
            end
            CMD_ROT_CCW: begin
               wheel_in  = {neg, pos, neg, pos};
               jog_start = 1'b1;
            end
            CMD_ROT_CW: begin
               wheel_in  = {pos, neg, pos, neg};
               jog_start = 1'b1;
            end
            CMD_STOP: begin
               wheel_in       = '0;
               ticks_in       = '0;
               active_in      = 1'b0;
               motors_written = 1'b1;
            end
            CMD_GRIP_TOG: begin
               open_in       = !open_ff;
               servo_in      = open_ff ? cfg.closed_angle : cfg.open_angle;
               servo_written = 1'b1;
            end
            CMD_GRIP_OPEN: begin
               open_in       = 1'b1;
               servo_in      = cfg.open_angle;
               servo_written = 1'b1;
            end
            CMD_GRIP_CLS: begin
               open_in       = 1'b0;
               servo_in      = cfg.closed_angle;
               servo_written = 1'b1;
            end
            default: ;
         endcase
         if (jog_start) begin
            ticks_in       = cfg.jog_ticks;
            active_in      = 1'b1;
            motors_written = 1'b1;
         end
      end
   end

   always_comb begin
      result.wheel_one      = wheel_in[0];
      result.wheel_two      = wheel_in[1];
      result.wheel_three    = wheel_in[2];
      result.wheel_four     = wheel_in[3];
      result.motors_written = motors_written;
      result.servo_angle    = servo_in;
      result.servo_written  = servo_written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= '0;
         active_ff <= 1'b0;
         open_ff   <= 1'b0;
         wheel_ff  <= '0;
         servo_ff  <= SERVO_RESET_ANGLE;
      end else if (item_en) begin
         ticks_ff  <= ticks_in;
         active_ff <= active_in;
         open_ff   <= open_in;
         wheel_ff  <= wheel_in;
         servo_ff  <= servo_in;
      end
   end

endmodule

// File: hw/rtl/mecanum_jog_command_controller_top.sv
// ----------------------------------------------------------------------------
// mecanum_jog_command_controller_top
// A taken request is held in the input register and its result is then held
// in the result register. Throughput: one item per cycle while rsp_stall is
// low; the two registers form a two-deep pipeline, so one more item is taken
// while a result waits. Reset is synchronous: wheels zero, no jog timed,
// gripper closed at ten degrees, registers reset, both pipeline stages empty.
// ----------------------------------------------------------------------------
module mecanum_jog_command_controller_top import mjcc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;
   logic    stage_valid_ff;
   logic    stage_valid_in;
   req_type stage_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    advance;
   logic    accept;

   mjcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mjcc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item_en (advance),
      .item    (stage_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// File: hw/rtl/mjcc_checker.sv
// ----------------------------------------------------------------------------
// mjcc_checker
// Port-level checks of the jog controller: reset, wheel range and pattern,
// result flags and the stalled result beat.
// ----------------------------------------------------------------------------
module mjcc_checker import mjcc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.wheel_one <= 8'sd100) && (rsp_data.wheel_one >= -8'sd100)
         && (rsp_data.wheel_four <= 8'sd100) && (rsp_data.wheel_four >= -8'sd100))
      else $error("wheel speed outside the clamp range");

   a_wheel_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.wheel_two == rsp_data.wheel_one)
         || (rsp_data.wheel_two == -rsp_data.wheel_one))
      else $error("wheel speeds differ in magnitude");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.motors_written && rsp_data.servo_written))
      else $error("one item wrote both motors and servo");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind mecanum_jog_command_controller_top mjcc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
